// File: hw/rtl/dqr_pkg.sv
// ----------------------------------------------------------------------------
// dqr_pkg: shared types and constants for the double-ended queue
// Request and status codes, cell commands, the neighbor link and FSM states.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_TRAVERSE   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_ROTATE
  } cell_cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic              occ;
    logic [DATA_W-1:0] val;
  } link_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] push_value;
    logic [DATA_W-1:0] head_value;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } fsm_t;

endpackage

// File: hw/rtl/dqr_if.sv
// ----------------------------------------------------------------------------
// dqr_if: request and response channel interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dqr_req_if;
  logic                                valid;
  logic                                ready;
  logic [dqr_pkg::REQ_W-1:0]           req_type;
  logic signed [dqr_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface dqr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [dqr_pkg::DATA_W-1:0]   out_value;
  logic [dqr_pkg::STAT_W-1:0]          status;
  logic                                last_of_run;

  modport source (output valid, out_value, status, last_of_run, input ready);
  modport sink   (input valid, out_value, status, last_of_run, output ready);
endinterface

// File: hw/rtl/dqr_cell.sv
// ----------------------------------------------------------------------------
// dqr_cell: one slot of the queue chain
// Holds one value and an occupied flag; moves data to/from its neighbors.
// ----------------------------------------------------------------------------
module dqr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dqr_pkg::cell_ctl_t ctl,
  input  dqr_pkg::link_t     prev_link,
  input  dqr_pkg::link_t     next_link,
  output dqr_pkg::link_t     cell_link
);

  logic                       occ_r, occ_nxt;
  logic [dqr_pkg::DATA_W-1:0] val_r, val_nxt;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    case (ctl.cmd)
      dqr_pkg::CMD_PUSH_FRONT: begin
        occ_nxt = prev_link.occ;
        val_nxt = prev_link.val;
      end
      dqr_pkg::CMD_PUSH_BACK: begin
        // first free slot takes the value
        if (!occ_r && prev_link.occ) begin
          occ_nxt = 1'b1;
          val_nxt = ctl.push_value;
        end
      end
      dqr_pkg::CMD_POP_FRONT: begin
        occ_nxt = next_link.occ;
        val_nxt = next_link.val;
      end
      dqr_pkg::CMD_POP_BACK: begin
        occ_nxt = occ_r && next_link.occ;
      end
      dqr_pkg::CMD_ROTATE: begin
        // shift toward the front; the tail slot takes the old head
        if (next_link.occ) begin
          val_nxt = next_link.val;
        end else if (occ_r) begin
          val_nxt = ctl.head_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign cell_link.occ = occ_r;
  assign cell_link.val = val_r;

endmodule

// File: hw/rtl/double_ended_queue_ring.sv
// ----------------------------------------------------------------------------
// double_ended_queue_ring: bounded double-ended queue of signed 32-bit values
// Latency: a response beat is registered in the cycle after its request beat.
// Throughput: push and pop requests are taken back to back; a traverse gives one
//   beat per stored entry, the chain rotating one slot per cycle when not stalled.
// Reset: synchronous, active low; queue empty, stored values undefined.
// ----------------------------------------------------------------------------
module double_ended_queue_ring #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dqr_req_if.sink   in_req,
  dqr_rsp_if.source out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  // Chain of cells: cell 0 is the front. Occupancy is a thermometer code,
  // so the tail is the last occupied cell.
  dqr_pkg::link_t    cell_q [DEPTH];
  dqr_pkg::link_t    prev_l [DEPTH];
  dqr_pkg::link_t    next_l [DEPTH];
  dqr_pkg::cell_ctl_t ctl;
  dqr_pkg::cell_cmd_t cmd;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        // push front enters here from the request payload
        assign prev_l[gi].occ = 1'b1;
        assign prev_l[gi].val = in_req.item_value;
      end else begin : g_mid
        assign prev_l[gi] = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_l[gi].occ = 1'b0;
        assign next_l[gi].val = '0;
      end else begin : g_body
        assign next_l[gi] = cell_q[gi+1];
      end

      dqr_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .prev_link (prev_l[gi]),
        .next_link (next_l[gi]),
        .cell_link (cell_q[gi])
      );
    end
  endgenerate

  assign ctl.cmd        = cmd;
  assign ctl.push_value = in_req.item_value;
  assign ctl.head_value = cell_q[0].val;

  // Pop back value: AND-OR select of the one-hot tail cell.
  logic [dqr_pkg::DATA_W-1:0] tail_val;
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val |
                 (cell_q[i].val & {dqr_pkg::DATA_W{cell_q[i].occ && !next_l[i].occ}});
    end
  end

  // Sequencer state
  dqr_pkg::fsm_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // next traverse position

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [dqr_pkg::DATA_W-1:0] out_val_r;
  dqr_pkg::status_t           out_st_r;
  logic                       out_last_r;

  logic                       slot_free, in_fire, is_full, is_empty, load;
  logic                       trav_last;
  logic [dqr_pkg::DATA_W-1:0] res_val;
  dqr_pkg::status_t           res_st;
  logic                       res_last;

  assign slot_free = !out_valid_r || out_rsp.ready;
  assign in_fire   = in_req.valid && in_req.ready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign trav_last = ((idx_r + CW'(1)) == count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dqr_pkg::S_IDLE: begin
        if (in_fire && in_req.req_type == dqr_pkg::REQ_TRAVERSE &&
            !is_empty && count_r != CW'(1)) begin
          state_nxt = dqr_pkg::S_TRAV;
        end
      end
      dqr_pkg::S_TRAV: begin
        if (slot_free && trav_last) begin
          state_nxt = dqr_pkg::S_IDLE;
        end
      end
      default: state_nxt = dqr_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_req.ready = 1'b0;
    cmd          = dqr_pkg::CMD_HOLD;
    load         = 1'b0;
    res_val      = '0;
    res_st       = dqr_pkg::ST_OK;
    res_last     = 1'b1;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    case (state_r)
      dqr_pkg::S_IDLE: begin
        in_req.ready = slot_free;
        // request beat taken (ready equals slot_free here)
        if (in_req.valid && slot_free) begin
          case (in_req.req_type)
            dqr_pkg::REQ_PUSH_FRONT, dqr_pkg::REQ_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                res_st = dqr_pkg::ST_FULL;   // value dropped
              end else begin
                cmd = (in_req.req_type == dqr_pkg::REQ_PUSH_FRONT) ?
                      dqr_pkg::CMD_PUSH_FRONT : dqr_pkg::CMD_PUSH_BACK;
                count_nxt = count_r + CW'(1);
              end
            end
            dqr_pkg::REQ_POP_FRONT, dqr_pkg::REQ_POP_BACK: begin
              load = 1'b1;
              if (is_empty) begin
                res_st = dqr_pkg::ST_EMPTY;
              end else if (in_req.req_type == dqr_pkg::REQ_POP_FRONT) begin
                cmd       = dqr_pkg::CMD_POP_FRONT;
                res_val   = cell_q[0].val;
                count_nxt = count_r - CW'(1);
              end else begin
                cmd       = dqr_pkg::CMD_POP_BACK;
                res_val   = tail_val;
                count_nxt = count_r - CW'(1);
              end
            end
            dqr_pkg::REQ_TRAVERSE: begin
              load = 1'b1;
              if (is_empty) begin
                res_st = dqr_pkg::ST_EMPTY;
              end else begin
                // emit the head and rotate; count rotations restore order
                cmd      = dqr_pkg::CMD_ROTATE;
                res_val  = cell_q[0].val;
                res_last = (count_r == CW'(1));
                idx_nxt  = CW'(1);
              end
            end
            default: begin
              // unknown request: consumed, no response
            end
          endcase
        end
      end
      dqr_pkg::S_TRAV: begin
        if (slot_free) begin
          load     = 1'b1;
          cmd      = dqr_pkg::CMD_ROTATE;
          res_val  = cell_q[0].val;
          res_last = trav_last;
          idx_nxt  = idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqr_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Response payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_val_r  <= res_val;
      out_st_r   <= res_st;
      out_last_r <= res_last;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.out_value   = out_val_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.last_of_run = out_last_r;

endmodule

// File: tb/sv/double_ended_queue_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_ring_tb: self-checking bench for the ring deque
// A directed table covers empty, full, wrap and unknown-request corners.
// Random bursts then fill, drain and mix the queue under three
// sender/receiver idle profiles. A shadow deque predicts every response
// beat, and each beat is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_tb;

  localparam int DEPTH          = dqr_pkg::DEPTH_DEF;
  localparam int REQ_W          = dqr_pkg::REQ_W;
  localparam int DATA_W         = dqr_pkg::DATA_W;
  localparam int RX_HOLD_CYCLES = 300;  // long receiver stall to back up the input
  localparam int DRAIN_CYCLES   = 8;    // settle time; each response is registered after its request
  localparam int TIMEOUT_NS     = 3_000_000;

  // Burst flavors for the random part.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  // Codes the block must drop without answering.
  localparam logic [REQ_W-1:0] REQ_BAD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_7 = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  // One response beat as the block should present it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    dqr_pkg::status_t         status;
    logic                     last;
  } rsp_beat_t;

  // Directed row; when pinned, the typed-in beat (or no beat) replaces the
  // shadow deque's answer. Repeated rows push value, value+1, ...
  typedef struct {
    logic [REQ_W-1:0]  code;
    logic [DATA_W-1:0] value;
    int                rep;
    bit                pinned;
    bit                has_beat;
    rsp_beat_t         beat;
  } dir_row_t;

  // Per offered request: whether its answer is pinned by the table.
  typedef struct packed {
    bit        pinned;
    bit        has_beat;
    rsp_beat_t beat;
  } pin_t;

  logic clk = 1'b0;
  logic rst_n;

  dqr_req_if req_ch();
  dqr_rsp_if rsp_ch();

  double_ended_queue_ring #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow deque state.
  logic signed [DATA_W-1:0] ring_vals [DEPTH];
  int                       ring_head = 0;
  int                       ring_fill = 0;

  rsp_beat_t owed_q[$];    // beats the block still owes, oldest first
  pin_t      pin_q[$];     // one entry per offered request, in offer order
  int        fail_count  = 0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asked  = 0;     // bumped by stimulus to request a long stall
  int hold_done   = 0;     // bumped by the receiver once a stall is served

  dir_row_t script [19];

  // --------------------------------------------------------------------------
  // Shadow deque: apply one accepted request, queue the beats it causes.
  // --------------------------------------------------------------------------
  task automatic deque_step(input logic [REQ_W-1:0] code,
                            input logic signed [DATA_W-1:0] v);
    int slot;
    case (code)
      dqr_pkg::REQ_PUSH_FRONT, dqr_pkg::REQ_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          owed_q.push_back('{'0, dqr_pkg::ST_FULL, 1'b1});  // full: value dropped
        end else begin
          if (code == dqr_pkg::REQ_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_vals[ring_head] = v;
          end else begin
            ring_vals[(ring_head + ring_fill) % DEPTH] = v;
          end
          ring_fill++;
          owed_q.push_back('{'0, dqr_pkg::ST_OK, 1'b1});
        end
      end
      dqr_pkg::REQ_POP_FRONT, dqr_pkg::REQ_POP_BACK: begin
        if (ring_fill == 0) begin
          owed_q.push_back('{'0, dqr_pkg::ST_EMPTY, 1'b1});
        end else begin
          if (code == dqr_pkg::REQ_POP_FRONT) begin
            slot      = ring_head;
            ring_head = (ring_head + 1) % DEPTH;
          end else begin
            slot = (ring_head + ring_fill - 1) % DEPTH;
          end
          ring_fill--;
          owed_q.push_back('{ring_vals[slot], dqr_pkg::ST_OK, 1'b1});
        end
      end
      dqr_pkg::REQ_TRAVERSE: begin
        if (ring_fill == 0) begin
          owed_q.push_back('{'0, dqr_pkg::ST_EMPTY, 1'b1});
        end else begin
          for (int i = 0; i < ring_fill; i++) begin
            owed_q.push_back('{ring_vals[(ring_head + i) % DEPTH], dqr_pkg::ST_OK,
                               (i == ring_fill - 1)});
          end
        end
      end
      default: ;  // unknown code: no beat, no state change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checker: responses first (a same-edge request can't answer yet), then
  // requests feed the shadow deque.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_check
    rsp_beat_t want;
    pin_t      pin;
    int        base;
    if (rst_n === 1'b1) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_q.size() == 0) begin
          $error("response beat with nothing owed: value %0d status %0d last %0b",
                 rsp_ch.out_value, rsp_ch.status, rsp_ch.last_of_run);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (rsp_ch.out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, rsp_ch.out_value);
            fail_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, rsp_ch.last_of_run);
            fail_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pin  = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        base = owed_q.size();
        deque_step(req_ch.req_type, req_ch.item_value);
        if (pin.pinned) begin
          // typed-in answer overrides; shadow state still advanced above
          while (owed_q.size() > base) void'(owed_q.pop_back());
          if (pin.has_beat) owed_q.push_back(pin.beat);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, plus a long counted stall on request.
  // --------------------------------------------------------------------------
  initial begin : rsp_sink
    int held;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n !== 1'b1) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < RX_HOLD_CYCLES; held++) @(posedge clk);
        hold_done++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the beat until it is taken.
  // valid stays high across back-to-back beats.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [REQ_W-1:0] code, input logic [DATA_W-1:0] v,
                          input bit pinned, input bit has_beat, input rsp_beat_t beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back('{pinned, has_beat, beat});
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= code;
    req_ch.item_value <= v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Bursts that lean toward filling, draining or mixing, so the queue
  // swings between empty and full and the head wraps both ways.
  task automatic spray_requests(input int count);
    int                mode;
    int                left;
    int                pick;
    logic [REQ_W-1:0]  code;
    logic [DATA_W-1:0] v;
    left = 0;
    mode = MODE_FILL;
    repeat (count) begin
      if (left == 0) begin
        mode = $urandom_range(MODE_MIX);
        left = $urandom_range(24, 6);
      end
      left--;
      pick = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          if (pick < 78)      code = $urandom_range(1) ? dqr_pkg::REQ_PUSH_FRONT
                                                       : dqr_pkg::REQ_PUSH_BACK;
          else if (pick < 90) code = dqr_pkg::REQ_TRAVERSE;
          else if (pick < 96) code = $urandom_range(1) ? dqr_pkg::REQ_POP_FRONT
                                                       : dqr_pkg::REQ_POP_BACK;
          else                code = REQ_W'($urandom_range(REQ_BAD_7, REQ_BAD_5));
        end
        MODE_DRAIN: begin
          if (pick < 78)      code = $urandom_range(1) ? dqr_pkg::REQ_POP_FRONT
                                                       : dqr_pkg::REQ_POP_BACK;
          else if (pick < 90) code = dqr_pkg::REQ_TRAVERSE;
          else if (pick < 96) code = $urandom_range(1) ? dqr_pkg::REQ_PUSH_FRONT
                                                       : dqr_pkg::REQ_PUSH_BACK;
          else                code = REQ_W'($urandom_range(REQ_BAD_7, REQ_BAD_5));
        end
        default: begin  // mixed
          if (pick < 94) code = REQ_W'($urandom_range(dqr_pkg::REQ_TRAVERSE,
                                                      dqr_pkg::REQ_PUSH_FRONT));
          else           code = REQ_W'($urandom_range(REQ_BAD_7, REQ_BAD_5));
        end
      endcase
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = '1;
        2:       v = VAL_MAX;
        3:       v = VAL_MIN;
        default: v = $urandom;
      endcase
      send_req(code, v, 1'b0, 1'b0, '0);
    end
  endtask

  // Park the sender until every owed beat has come back.
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = '0;
    req_ch.item_value = '0;

    script = '{
      // empty corners, value field ignored
      '{dqr_pkg::REQ_POP_FRONT,  '0,      1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_EMPTY, 1'b1}},
      '{dqr_pkg::REQ_POP_BACK,   VAL_MAX, 1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_EMPTY, 1'b1}},
      '{dqr_pkg::REQ_TRAVERSE,   '1,      1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_EMPTY, 1'b1}},
      '{REQ_BAD_5,               '0,      1, 1'b1, 1'b0, '0},
      // push front from an empty ring wraps the head below zero
      '{dqr_pkg::REQ_PUSH_FRONT, VAL_MAX, 1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_OK, 1'b1}},
      '{dqr_pkg::REQ_PUSH_BACK,  VAL_MIN, 1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_OK, 1'b1}},
      '{dqr_pkg::REQ_TRAVERSE,   '0,      1, 1'b0, 1'b0, '0},
      '{dqr_pkg::REQ_POP_BACK,   '0,      1, 1'b1, 1'b1, '{VAL_MIN, dqr_pkg::ST_OK, 1'b1}},
      '{dqr_pkg::REQ_POP_FRONT,  '0,      1, 1'b1, 1'b1, '{VAL_MAX, dqr_pkg::ST_OK, 1'b1}},
      '{REQ_BAD_6,               '1,      1, 1'b1, 1'b0, '0},
      '{REQ_BAD_7,               VAL_MIN, 1, 1'b1, 1'b0, '0},
      // fill to capacity from both ends
      '{dqr_pkg::REQ_PUSH_FRONT, '0,            8, 1'b0, 1'b0, '0},
      '{dqr_pkg::REQ_PUSH_BACK,  32'hFFFF_FFF8, 8, 1'b0, 1'b0, '0},
      // full: value dropped
      '{dqr_pkg::REQ_PUSH_FRONT, '1,    1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_FULL, 1'b1}},
      '{dqr_pkg::REQ_PUSH_BACK,  32'd1, 1, 1'b1, 1'b1, '{'0, dqr_pkg::ST_FULL, 1'b1}},
      // full traverse gives the longest run
      '{dqr_pkg::REQ_TRAVERSE,   '0,      1, 1'b0, 1'b0, '0},
      '{dqr_pkg::REQ_POP_FRONT,  '0,      1, 1'b0, 1'b0, '0},
      '{dqr_pkg::REQ_POP_BACK,   '0,      1, 1'b0, 1'b0, '0},
      '{dqr_pkg::REQ_TRAVERSE,   '0,      1, 1'b0, 1'b0, '0}
    };

    tx_idle_pct = 11;
    rx_idle_pct = 76;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      for (int k = 0; k < script[r].rep; k++) begin
        send_req(script[r].code, script[r].value + k, script[r].pinned,
                 script[r].has_beat, script[r].beat);
      end
    end

    spray_requests(96);
    wait_quiet();

    tx_idle_pct = 76;
    rx_idle_pct = 11;
    spray_requests(96);
    wait_quiet();

    // no idling; open with a long receiver stall so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asked++;
    spray_requests(100);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dqr_pkg.sv
hw/rtl/dqr_if.sv
hw/rtl/dqr_cell.sv
hw/rtl/double_ended_queue_ring.sv
tb/sv/double_ended_queue_ring_tb.sv
